// ===== src/dosc_pkg.sv =====
// Shared constants, codes and command types of the damped oscillator RK4 stepper.
// Depends on nothing; every other file of the block uses it.
package dosc_pkg;

   // Number format: signed Q16.16 in a 32-bit word.
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int CFG_W     = DATA_W - 1;
   localparam int IDX_W     = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 5;

   localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Exact unsigned division by six for 32-bit operands: (n * RECIP6) >> DIV6_SHIFT.
   localparam logic [DATA_W-1:0] RECIP6     = 32'hAAAA_AAAB;
   localparam int                DIV6_SHIFT = 34;
   localparam logic [DATA_W-1:0] DIV6_BIAS  = 32'd3;

   // Register reset values.
   localparam logic [CFG_W-1:0] STEP_SIZE_RST = CFG_W'(655);
   localparam logic [CFG_W-1:0] NAT_FREQ_RST  = CFG_W'(65536);
   localparam logic [CFG_W-1:0] DAMPING_RST   = '0;

   // Register map.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE = 2'd0,
      CSR_NAT_FREQ  = 2'd1,
      CSR_DAMPING   = 2'd2
   } csr_idx_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   // First multiplier operand.
   typedef enum logic [2:0] {
      OPA_OM,
      OPA_WX,
      OPA_W2,
      OPA_G2,
      OPA_DT,
      OPA_V,
      OPA_DIV_TQ,
      OPA_DIV_ACC
   } opa_type;

   // Second multiplier operand.
   typedef enum logic [3:0] {
      OPB_X,
      OPB_OM,
      OPB_WX,
      OPB_V,
      OPB_KV,
      OPB_PX,
      OPB_PV,
      OPB_SX,
      OPB_SV,
      OPB_RECIP
   } opb_type;

   // Product scaling: Q multiply, Q multiply with a factor one half, divide by six.
   typedef enum logic [1:0] {
      SH_Q,
      SH_HALF,
      SH_DIV
   } sh_type;

   // What the write-back stage does with a finished product.
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_WX,
      ACT_W2,
      ACT_E_SET,
      ACT_E_ADD,
      ACT_ACC,
      ACT_ACC_SX1,
      ACT_ACC_SX2,
      ACT_KV_INIT,
      ACT_KV,
      ACT_PX,
      ACT_PX_SV2,
      ACT_PV,
      ACT_TQ_SV1
   } act_type;

   typedef struct packed {
      opa_type a_sel;
      opb_type b_sel;
      sh_type  sh;
      act_type act;
   } uop_type;

   // Controller to datapath.
   typedef struct packed {
      logic    load;
      logic    op_valid;
      uop_type uop;
      logic    commit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== src/dosc_ifs.sv =====
// Handshake channel interfaces of the oscillator stepper: request, response and
// register write. Depends on dosc_pkg for widths.
interface dosc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              start_req;
   logic signed [dosc_pkg::DATA_W-1:0] start_position;
   logic signed [dosc_pkg::DATA_W-1:0] start_velocity;

   modport source (output valid, start_req, start_position, start_velocity, input ready);
   modport sink (input valid, start_req, start_position, start_velocity, output ready);
endinterface

interface dosc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dosc_pkg::IDX_W-1:0]        step_index;
   logic signed [dosc_pkg::DATA_W-1:0] position;
   logic signed [dosc_pkg::DATA_W-1:0] velocity;
   logic [dosc_pkg::CFG_W-1:0]        energy;

   modport source (output valid, step_index, position, velocity, energy, input ready);
   modport sink (input valid, step_index, position, velocity, energy, output ready);
endinterface

interface dosc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dosc_pkg::CSR_IDX_W-1:0]    index;
   logic [dosc_pkg::DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/dosc_ctrl.sv =====
// Sequencer of the oscillator stepper: walks the operation list of one RK4 step
// through the shared multiplier. Depends on dosc_pkg.
module dosc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dosc_pkg::status_type status,
   output dosc_pkg::cmd_type    cmd
);
   import dosc_pkg::*;

   // The last slot issues nothing and lets the final product write back.
   localparam logic [STEP_W-1:0] DRAIN_STEP = STEP_W'(22);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // Operation list. A result lands only after the product register and the write-back,
   // so an operation never reads a value written by the slot just before it.
   function automatic uop_type ucode(input logic [STEP_W-1:0] step);
      uop_type u;
      u = '{OPA_DT, OPB_X, SH_Q, ACT_NONE};
      case (step)
         5'd0:  u = '{OPA_OM,      OPB_X,     SH_Q,    ACT_WX};
         5'd1:  u = '{OPA_OM,      OPB_OM,    SH_Q,    ACT_W2};
         5'd2:  u = '{OPA_WX,      OPB_WX,    SH_HALF, ACT_E_SET};
         5'd3:  u = '{OPA_W2,      OPB_X,     SH_Q,    ACT_ACC};
         5'd4:  u = '{OPA_G2,      OPB_V,     SH_Q,    ACT_KV_INIT};
         5'd5:  u = '{OPA_DT,      OPB_V,     SH_HALF, ACT_PX};
         5'd6:  u = '{OPA_DT,      OPB_KV,    SH_HALF, ACT_PV};
         5'd7:  u = '{OPA_W2,      OPB_PX,    SH_Q,    ACT_ACC_SX2};
         5'd8:  u = '{OPA_G2,      OPB_PV,    SH_Q,    ACT_KV};
         5'd9:  u = '{OPA_DT,      OPB_PV,    SH_HALF, ACT_PX_SV2};
         5'd10: u = '{OPA_DT,      OPB_KV,    SH_HALF, ACT_PV};
         5'd11: u = '{OPA_W2,      OPB_PX,    SH_Q,    ACT_ACC_SX2};
         5'd12: u = '{OPA_G2,      OPB_PV,    SH_Q,    ACT_KV};
         5'd13: u = '{OPA_DT,      OPB_PV,    SH_Q,    ACT_PX_SV2};
         5'd14: u = '{OPA_DT,      OPB_KV,    SH_Q,    ACT_PV};
         5'd15: u = '{OPA_W2,      OPB_PX,    SH_Q,    ACT_ACC_SX1};
         5'd16: u = '{OPA_G2,      OPB_PV,    SH_Q,    ACT_KV};
         5'd17: u = '{OPA_DT,      OPB_SX,    SH_Q,    ACT_TQ_SV1};
         5'd18: u = '{OPA_V,       OPB_V,     SH_HALF, ACT_E_ADD};
         5'd19: u = '{OPA_DT,      OPB_SV,    SH_Q,    ACT_ACC};
         5'd20: u = '{OPA_DIV_TQ,  OPB_RECIP, SH_DIV,  ACT_PX};
         5'd21: u = '{OPA_DIV_ACC, OPB_RECIP, SH_DIV,  ACT_PV};
         default: u = '{OPA_DT, OPB_X, SH_Q, ACT_NONE};
      endcase
      return u;
   endfunction

   // State and slot registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.uop   = ucode(step_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == DRAIN_STEP) begin
               state_in = ST_OUT;
            end else begin
               cmd.op_valid = 1'b1;
               step_in      = step_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN && step_ff == '0))
      else $error("Accepted transaction did not start the operation list.");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= DRAIN_STEP))
      else $error("Operation slot ran past the drain slot.");

   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (status.out_free && !cmd.op_valid))
      else $error("Result committed while the output register was occupied.");
`endif

endmodule

// ===== src/dosc_dp.sv =====
// Datapath of the oscillator stepper: registers, shared two-stage multiplier with
// rounding and saturation, write-back adders and the output register. Uses dosc_pkg.
module dosc_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start_req,
   input  logic signed [dosc_pkg::DATA_W-1:0] start_position,
   input  logic signed [dosc_pkg::DATA_W-1:0] start_velocity,
   input  dosc_pkg::cmd_type                  cmd,
   output dosc_pkg::status_type               status,
   dosc_rsp_if.source                         rsp,
   dosc_csr_if.sink                           csr
);
   import dosc_pkg::*;

   localparam logic [PROD_W-1:0] RND_Q    = PROD_W'(1) << (FRAC_W - 1);
   localparam logic [PROD_W-1:0] RND_H    = PROD_W'(1) << FRAC_W;
   localparam logic [PROD_W-1:0] LIM_POS  = PROD_W'(SMAX);
   localparam logic [PROD_W-1:0] LIM_NEG  = LIM_POS + 1'b1;

   typedef logic signed [DATA_W-1:0] word_type;

   // Saturating add on signed words.
   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? SMIN : SMAX;
      end
      return s[DATA_W-1:0];
   endfunction

   function automatic word_type sat_neg(input word_type a);
      return (a == SMIN) ? SMAX : -a;
   endfunction

   // Magnitude of a signed word; the most negative value maps to 2^(DATA_W-1).
   function automatic logic [DATA_W-1:0] magnitude(input word_type a);
      return a[DATA_W-1] ? (~a + 1'b1) : a;
   endfunction

   // Configuration registers.
   logic [CFG_W-1:0] dt_ff, om_ff, gamma_ff;

   // Oscillator state and working registers.
   word_type          x_ff, v_ff, x_in, v_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   word_type          g2_ff, g2_in;
   word_type          wx_ff, wx_in, w2_ff, w2_in, e_ff, e_in;
   word_type          acc_ff, acc_in, kv_ff, kv_in, tq_ff, tq_in;
   word_type          px_ff, px_in, pv_ff, pv_in, sx_ff, sx_in, sv_ff, sv_in;

   // Multiplier stages.
   word_type            a_val, b_val;
   logic                a_div;
   logic [DATA_W-1:0]   mag_a, mag_b;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                neg_ff, neg_in;
   sh_type              sh_ff;
   act_type             act_ff, act_in;
   logic [PROD_W-1:0]   q;
   logic [DATA_W-1:0]   mag_r;
   word_type            r, accel;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff;
   word_type          rsp_pos_ff, rsp_vel_ff;
   logic [CFG_W-1:0]  rsp_energy_ff;

   // Register writes are always taken; the upper data bit is dropped.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff    <= STEP_SIZE_RST;
         om_ff    <= NAT_FREQ_RST;
         gamma_ff <= DAMPING_RST;
      end else if (csr.valid) begin
         case (csr_idx_type'(csr.index))
            CSR_STEP_SIZE: dt_ff    <= csr.data[CFG_W-1:0];
            CSR_NAT_FREQ:  om_ff    <= csr.data[CFG_W-1:0];
            CSR_DAMPING:   gamma_ff <= csr.data[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Operand selection and magnitude product.
   always_comb begin
      case (cmd.uop.a_sel)
         OPA_OM:      a_val = {1'b0, om_ff};
         OPA_WX:      a_val = wx_ff;
         OPA_W2:      a_val = w2_ff;
         OPA_G2:      a_val = g2_ff;
         OPA_DT:      a_val = {1'b0, dt_ff};
         OPA_V:       a_val = v_ff;
         OPA_DIV_TQ:  a_val = tq_ff;
         OPA_DIV_ACC: a_val = acc_ff;
         default:     a_val = '0;
      endcase
      case (cmd.uop.b_sel)
         OPB_X:   b_val = x_ff;
         OPB_OM:  b_val = {1'b0, om_ff};
         OPB_WX:  b_val = wx_ff;
         OPB_V:   b_val = v_ff;
         OPB_KV:  b_val = kv_ff;
         OPB_PX:  b_val = px_ff;
         OPB_PV:  b_val = pv_ff;
         OPB_SX:  b_val = sx_ff;
         OPB_SV:  b_val = sv_ff;
         default: b_val = '0;
      endcase
      a_div  = (cmd.uop.a_sel == OPA_DIV_TQ) || (cmd.uop.a_sel == OPA_DIV_ACC);
      // Division by six rounds half away from zero: (|a| + 3) / 6 with a's sign.
      mag_a  = a_div ? (magnitude(a_val) + DIV6_BIAS) : magnitude(a_val);
      mag_b  = (cmd.uop.b_sel == OPB_RECIP) ? RECIP6 : magnitude(b_val);
      neg_in = a_div ? a_val[DATA_W-1] : (a_val[DATA_W-1] ^ b_val[DATA_W-1]);
      prod_in = PROD_W'(mag_a) * PROD_W'(mag_b);
      act_in  = cmd.op_valid ? cmd.uop.act : ACT_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ACT_NONE;
      end else begin
         act_ff <= act_in;
      end
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      sh_ff   <= cmd.uop.sh;
   end

   // Rounding shift and saturation of the registered product.
   always_comb begin
      case (sh_ff)
         SH_Q:    q = (prod_ff + RND_Q) >> FRAC_W;
         SH_HALF: q = (prod_ff + RND_H) >> (FRAC_W + 1);
         SH_DIV:  q = prod_ff >> DIV6_SHIFT;
         default: q = '0;
      endcase
      if (neg_ff) begin
         mag_r = (q > LIM_NEG) ? LIM_NEG[DATA_W-1:0] : q[DATA_W-1:0];
         r     = ~mag_r + 1'b1;
      end else begin
         mag_r = (q > LIM_POS) ? LIM_POS[DATA_W-1:0] : q[DATA_W-1:0];
         r     = mag_r;
      end
      accel = sat_neg(sat_add(acc_ff, r));
   end

   // Write-back of products and the load and commit of the oscillator state.
   always_comb begin
      x_in   = x_ff;
      v_in   = v_ff;
      idx_in = idx_ff;
      g2_in  = g2_ff;
      wx_in  = wx_ff;
      w2_in  = w2_ff;
      e_in   = e_ff;
      acc_in = acc_ff;
      kv_in  = kv_ff;
      tq_in  = tq_ff;
      px_in  = px_ff;
      pv_in  = pv_ff;
      sx_in  = sx_ff;
      sv_in  = sv_ff;

      case (act_ff)
         ACT_WX:      wx_in = r;
         ACT_W2:      w2_in = r;
         ACT_E_SET:   e_in  = r;
         ACT_E_ADD:   e_in  = sat_add(e_ff, r);
         ACT_ACC:     acc_in = r;
         ACT_ACC_SX1: begin
            acc_in = r;
            sx_in  = sat_add(sx_ff, pv_ff);
         end
         ACT_ACC_SX2: begin
            acc_in = r;
            sx_in  = sat_add(sx_ff, sat_add(pv_ff, pv_ff));
         end
         ACT_KV_INIT: begin
            kv_in = accel;
            sv_in = accel;
         end
         ACT_KV:      kv_in = accel;
         ACT_PX:      px_in = sat_add(x_ff, r);
         ACT_PX_SV2: begin
            px_in = sat_add(x_ff, r);
            sv_in = sat_add(sv_ff, sat_add(kv_ff, kv_ff));
         end
         ACT_PV:      pv_in = sat_add(v_ff, r);
         ACT_TQ_SV1: begin
            tq_in = r;
            sv_in = sat_add(sv_ff, kv_ff);
         end
         default: begin
         end
      endcase

      // Each request loads a run, with new values on a start; x's first slope is the velocity.
      if (cmd.load) begin
         g2_in = sat_add({1'b0, gamma_ff}, {1'b0, gamma_ff});
         if (start_req) begin
            x_in   = start_position;
            v_in   = start_velocity;
            idx_in = '0;
            sx_in  = start_velocity;
         end else begin
            sx_in  = v_ff;
         end
      end

      // The stepped state replaces the current one as its sample leaves.
      if (cmd.commit) begin
         x_in   = px_ff;
         v_in   = pv_ff;
         idx_in = (idx_ff == '1) ? idx_ff : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         v_ff   <= '0;
         idx_ff <= '0;
      end else begin
         x_ff   <= x_in;
         v_ff   <= v_in;
         idx_ff <= idx_in;
      end
      g2_ff  <= g2_in;
      wx_ff  <= wx_in;
      w2_ff  <= w2_in;
      e_ff   <= e_in;
      acc_ff <= acc_in;
      kv_ff  <= kv_in;
      tq_ff  <= tq_in;
      px_ff  <= px_in;
      pv_ff  <= pv_in;
      sx_ff  <= sx_in;
      sv_ff  <= sv_in;
   end

   // Output register: filled on commit, emptied when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.commit) begin
         rsp_idx_ff    <= idx_ff;
         rsp_pos_ff    <= x_ff;
         rsp_vel_ff    <= v_ff;
         rsp_energy_ff <= e_ff[CFG_W-1:0];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.step_index = rsp_idx_ff;
   assign rsp.position   = rsp_pos_ff;
   assign rsp.velocity   = rsp_vel_ff;
   assign rsp.energy     = rsp_energy_ff;

   assign status.out_free = !rsp_valid_ff || rsp.ready;

`ifndef SYNTH
   a_commit_fills_output: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("Committed result did not reach the output register.");

   a_start_clears_index: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && start_req) |=> (idx_ff == '0))
      else $error("Start transaction did not clear the step index.");
`endif

endmodule

// ===== src/damped_oscillator_rk4_step.sv =====
// Damped harmonic oscillator, one fourth-order Runge-Kutta step per request.
//
// Channels: req_chan carries a start flag with an initial position and velocity;
// rsp_chan returns the step index, position, velocity and energy as they stood
// before the step; csr_chan writes step_size (0), natural_frequency (1) and
// damping_rate (2). Position and velocity are signed Q16.16, energy and the
// registers unsigned Q15.16; register writes are always taken and should only
// be issued while no request is in flight. A request is taken only when the
// block is idle, so the next one is not accepted before the last has been
// computed and committed to the output register. A step is a list of 22
// operations, issued one per cycle to the single shared multiplier, whose two
// stages are the product register and the write-back.
// A finished response sits in an output register; the next request is accepted
// and computed while it waits, and only the hand-over of the new result waits
// for the receiver to take the old one.
// Reset: synchronous, active high. Position, velocity and step index clear to
// zero, and the registers return to dt = 655, omega = 1.0, gamma = 0.
// Depends on dosc_pkg, dosc_ifs, dosc_ctrl and dosc_dp.
module damped_oscillator_rk4_step (
   input  logic      clock,
   input  logic      reset,
   dosc_req_if.sink  req_chan,
   dosc_rsp_if.source rsp_chan,
   dosc_csr_if.sink  csr_chan
);
   import dosc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_chan.ready = req_ready;

   // Sequencer.
   dosc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, state and output register.
   dosc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .start_req      (req_chan.start_req),
      .start_position (req_chan.start_position),
      .start_velocity (req_chan.start_velocity),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp_chan),
      .csr            (csr_chan)
   );

endmodule
